>>> hw/rtl/dccs_pkg.sv
// Shared types, codes and constants of the dock charge contact supervisor.
`default_nettype none
package dccs_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned MV_W = 16;
	localparam int unsigned MA_W = 16;
	localparam int unsigned SPEED_W = 6;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned TIMEOUT_W = 16;
	localparam int unsigned RETRY_W = 4;
	localparam int unsigned DOCK_SPEED_W = 10;

	localparam logic [MV_W-1:0] COMPLETE_MV = 16'd28500;
	localparam logic signed [MA_W-1:0] COMPLETE_MA = 16'sd100;
	localparam logic [TIME_W-1:0] MIN_CHARGE_MS = 32'd60000;
	localparam logic [SPEED_W-1:0] CREEP_CAP_MMPS = 6'd50;
	localparam logic [SPEED_W-1:0] FIRST_CREEP_MMPS = 6'd20;

	localparam logic [TIMEOUT_W-1:0] CONTACT_TIMEOUT_RST = 16'd3000;
	localparam logic [RETRY_W-1:0] MAX_RETRIES_RST = 4'd3;
	localparam logic [TIMEOUT_W-1:0] APPROACH_RST = 16'd2000;
	localparam logic [DOCK_SPEED_W-1:0] DOCK_SPEED_RST = 10'd100;
	localparam logic [MV_W-1:0] BATTERY_LOW_RST = 16'd21000;

	typedef enum logic [1:0] {
		KIND_TICK = 2'd0,
		KIND_ENTER = 2'd1,
		KIND_UNDERVOLT = 2'd2,
		KIND_START = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		MOT_NONE = 2'd0,
		MOT_STOP = 2'd1,
		MOT_FWD = 2'd2
	} motor_t;

	typedef enum logic [1:0] {
		OP_STAY = 2'd0,
		OP_DOCK = 2'd1,
		OP_ERROR = 2'd2,
		OP_UNDOCK = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REFUSE_NONE = 2'd0,
		REFUSE_LOW = 2'd1,
		REFUSE_ROUTE = 2'd2
	} refuse_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CONTACT_TIMEOUT = 3'd0,
		CFG_MAX_RETRIES = 3'd1,
		CFG_APPROACH = 3'd2,
		CFG_DOCK_SPEED = 3'd3,
		CFG_BATTERY_LOW = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [TIMEOUT_W-1:0] contact_timeout_ms;
		logic [RETRY_W-1:0] max_retries;
		logic [TIMEOUT_W-1:0] approach_ms;
		logic [DOCK_SPEED_W-1:0] dock_speed_mmps;
		logic [MV_W-1:0] battery_low_mv;
	} cfg_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [TIME_W-1:0] now_ms;
		logic charger_connected;
		logic [MV_W-1:0] voltage_mv;
		logic signed [MA_W-1:0] current_ma;
		logic route_ok;
	} item_t;

	typedef struct packed {
		motor_t motor_cmd;
		logic [SPEED_W-1:0] speed_mmps;
		op_t next_op;
		logic complete_event;
		refuse_t start_refused;
	} result_t;

endpackage
`default_nettype wire

>>> hw/rtl/dccs_if.sv
// Handshake channel interfaces for items, results and register writes.
`default_nettype none
interface dccs_item_if;
	import dccs_pkg::*;
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [TIME_W-1:0] now_ms;
	logic charger_connected;
	logic [MV_W-1:0] voltage_mv;
	logic signed [MA_W-1:0] current_ma;
	logic route_ok;
	modport source (output valid, kind, now_ms, charger_connected, voltage_mv, current_ma,
		route_ok, input ready);
	modport sink (input valid, kind, now_ms, charger_connected, voltage_mv, current_ma,
		route_ok, output ready);
endinterface

interface dccs_result_if;
	import dccs_pkg::*;
	logic valid;
	logic ready;
	logic [1:0] motor_cmd;
	logic [SPEED_W-1:0] speed_mmps;
	logic [1:0] next_op;
	logic complete_event;
	logic [1:0] start_refused;
	modport source (output valid, motor_cmd, speed_mmps, next_op, complete_event,
		start_refused, input ready);
	modport sink (input valid, motor_cmd, speed_mmps, next_op, complete_event,
		start_refused, output ready);
endinterface

interface dccs_cfg_if;
	import dccs_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/dock_charge_contact_supervisor_unit.sv
// Top level of the dock charge contact supervisor.
// Each input beat (tick, enter charging, undervoltage or timetable start) gives
// exactly one result beat. A beat is captured in an input register, evaluated
// against the supervisor state in one pass of compares and 32-bit adds, and the
// result lands in an output register once that register has room; state is
// updated at the same edge. One beat is taken every cycle, and the input keeps
// flowing while a result waits, until both registers are full and the result
// is not taken. Register writes are registered and must be made while no
// beat is in flight.
`default_nettype none
module dock_charge_contact_supervisor_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	dccs_item_if.sink       item,
	dccs_result_if.source   result,
	dccs_cfg_if.sink        cfg
);
	import dccs_pkg::*;

	cfg_t regs;
	item_t item_s1;
	logic valid_s1;
	result_t res_core;
	result_t res_s2;
	logic valid_s2;
	logic adv;

	assign adv = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || adv;

	dccs_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	dccs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.item   (item_s1),
		.regs   (regs),
		.res    (res_core)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item.valid && item.ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.kind <= item.kind;
			item_s1.now_ms <= item.now_ms;
			item_s1.charger_connected <= item.charger_connected;
			item_s1.voltage_mv <= item.voltage_mv;
			item_s1.current_ma <= item.current_ma;
			item_s1.route_ok <= item.route_ok;
		end
		if (adv) begin
			res_s2 <= res_core;
		end
	end

	assign result.valid = valid_s2;
	assign result.motor_cmd = res_s2.motor_cmd;
	assign result.speed_mmps = res_s2.speed_mmps;
	assign result.next_op = res_s2.next_op;
	assign result.complete_event = res_s2.complete_event;
	assign result.start_refused = res_s2.start_refused;
endmodule
`default_nettype wire

>>> hw/rtl/dccs_cfg_regs.sv
// Configuration register file of the supervisor.
`default_nettype none
module dccs_cfg_regs (
	input  wire logic           clk,
	input  wire logic           arst_n,
	dccs_cfg_if.sink            cfg,
	output dccs_pkg::cfg_t      regs
);
	import dccs_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.contact_timeout_ms <= CONTACT_TIMEOUT_RST;
			regs_q.max_retries <= MAX_RETRIES_RST;
			regs_q.approach_ms <= APPROACH_RST;
			regs_q.dock_speed_mmps <= DOCK_SPEED_RST;
			regs_q.battery_low_mv <= BATTERY_LOW_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_CONTACT_TIMEOUT: regs_q.contact_timeout_ms <= cfg.data;
				CFG_MAX_RETRIES: regs_q.max_retries <= cfg.data[RETRY_W-1:0];
				CFG_APPROACH: regs_q.approach_ms <= cfg.data;
				CFG_DOCK_SPEED: regs_q.dock_speed_mmps <= cfg.data[DOCK_SPEED_W-1:0];
				CFG_BATTERY_LOW: regs_q.battery_low_mv <= cfg.data;
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/dccs_core.sv
// Supervisor state and the single-pass evaluation of one beat.
`default_nettype none
module dccs_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  dccs_pkg::item_t     item,
	input  dccs_pkg::cfg_t      regs,
	output dccs_pkg::result_t   res
);
	import dccs_pkg::*;

	logic retry_active_q, retry_active_d;
	logic [TIME_W-1:0] retry_deadline_q, retry_deadline_d;
	logic [RETRY_W-1:0] retry_count_q, retry_count_d;
	logic complete_flag_q, complete_flag_d;
	logic [TIME_W-1:0] charge_start_q, charge_start_d;

	logic [TIME_W-1:0] since_deadline;
	logic [TIME_W-1:0] elapsed;
	logic [RETRY_W-1:0] retry_lim;
	logic [SPEED_W-1:0] creep_speed;
	logic done;

	always_comb begin
		since_deadline = item.now_ms - retry_deadline_q;
		elapsed = item.now_ms - charge_start_q;
		retry_lim = (regs.max_retries == '0) ? RETRY_W'(1) : regs.max_retries;
		creep_speed = (regs.dock_speed_mmps < DOCK_SPEED_W'(CREEP_CAP_MMPS))
			? regs.dock_speed_mmps[SPEED_W-1:0] : CREEP_CAP_MMPS;
		done = !complete_flag_q && (item.voltage_mv >= COMPLETE_MV)
			&& (item.current_ma < COMPLETE_MA) && (elapsed > MIN_CHARGE_MS);
	end

	always_comb begin
		retry_active_d = retry_active_q;
		retry_deadline_d = retry_deadline_q;
		retry_count_d = retry_count_q;
		complete_flag_d = complete_flag_q;
		charge_start_d = charge_start_q;
		res = '{motor_cmd: MOT_NONE, speed_mmps: '0, next_op: OP_STAY,
			complete_event: 1'b0, start_refused: REFUSE_NONE};
		unique case (kind_t'(item.kind))
			KIND_TICK: begin
				if (retry_active_q) begin
					if (item.charger_connected) begin
						retry_active_d = 1'b0;
						retry_deadline_d = '0;
						charge_start_d = item.now_ms;
						res.motor_cmd = MOT_STOP;
					end else if (since_deadline[TIME_W-1]) begin
						res.motor_cmd = MOT_FWD;
						res.speed_mmps = creep_speed;
					end else begin
						retry_active_d = 1'b0;
						res.motor_cmd = MOT_STOP;
						res.next_op = OP_DOCK;
					end
				end else if (!item.charger_connected) begin
					if (elapsed <= TIME_W'(regs.contact_timeout_ms)) begin
						if (retry_count_q >= retry_lim) begin
							res.next_op = OP_ERROR;
						end else begin
							retry_count_d = retry_count_q + RETRY_W'(1);
							retry_active_d = 1'b1;
							retry_deadline_d = item.now_ms + TIME_W'(regs.approach_ms);
							res.motor_cmd = MOT_FWD;
							res.speed_mmps = FIRST_CREEP_MMPS;
						end
					end else begin
						res.motor_cmd = MOT_STOP;
						res.next_op = OP_DOCK;
					end
				end else if (done) begin
					complete_flag_d = 1'b1;
					res.complete_event = 1'b1;
				end
			end
			KIND_ENTER: begin
				res.motor_cmd = MOT_STOP;
				retry_active_d = 1'b0;
				retry_deadline_d = '0;
				retry_count_d = '0;
				complete_flag_d = 1'b0;
				charge_start_d = item.now_ms;
			end
			KIND_UNDERVOLT: begin
				res.next_op = OP_ERROR;
			end
			KIND_START: begin
				if (item.voltage_mv < regs.battery_low_mv) begin
					res.start_refused = REFUSE_LOW;
				end else if (!item.route_ok) begin
					res.start_refused = REFUSE_ROUTE;
				end else begin
					res.next_op = OP_UNDOCK;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_active_q <= 1'b0;
			retry_deadline_q <= '0;
			retry_count_q <= '0;
			complete_flag_q <= 1'b0;
			charge_start_q <= '0;
		end else if (en) begin
			retry_active_q <= retry_active_d;
			retry_deadline_q <= retry_deadline_d;
			retry_count_q <= retry_count_d;
			complete_flag_q <= complete_flag_d;
			charge_start_q <= charge_start_d;
		end
	end
endmodule
`default_nettype wire
